### design/smceq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor matrix change event queue: shared package
// Field widths, command and event codes, controller types and helpers.
// ----------------------------------------------------------------------------
package smceq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int GRID_ROWS_DEF   = 8;
  localparam int GRID_COLS_DEF   = 8;

  localparam int KIND_W    = 3;
  localparam int MAP_W     = 64;
  localparam int TIME_W    = 32;
  localparam int IDX_W     = 8;
  localparam int QRY_W     = 4;
  localparam int EKIND_W   = 2;
  localparam int POS_W     = 3;
  localparam int BIT_W     = 6;
  localparam int CNT_OUT_W = 6;
  localparam int DROP_W    = 16;

  localparam logic [KIND_W-1:0] CMD_POLL        = 3'd0;
  localparam logic [KIND_W-1:0] CMD_SYNC        = 3'd1;
  localparam logic [KIND_W-1:0] CMD_PEEK        = 3'd2;
  localparam logic [KIND_W-1:0] CMD_CONSUME     = 3'd3;
  localparam logic [KIND_W-1:0] CMD_CLEAR_QUEUE = 3'd4;
  localparam logic [KIND_W-1:0] CMD_CLEAR_OVF   = 3'd5;

  localparam logic [EKIND_W-1:0] EVT_SYNCED = 2'd0;
  localparam logic [EKIND_W-1:0] EVT_PLACED = 2'd1;
  localparam logic [EKIND_W-1:0] EVT_LIFTED = 2'd2;

  typedef struct packed {
    logic [EKIND_W-1:0] kind;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [TIME_W-1:0]  stamp;
  } event_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_LOOKUP,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic apply;
    logic scan_step;
    logic lookup;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_poll;
    logic scan_done;
    logic out_free;
  } ctl_status_t;

  function automatic logic [MAP_W-1:0] grid_mask(input int rows, input int cols);
    logic [MAP_W-1:0] m;
    m = '0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        if (r < rows && c < cols) begin
          m[r*8+c] = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

### design/sensor_matrix_change_event_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor matrix change event queue: top level
// Change detection over a presence-sensor grid feeding an event ring queue.
// ----------------------------------------------------------------------------
// Usage: one command transaction enters on in_valid/in_stall and produces
// exactly one result transaction on out_valid/out_stall. A command is taken
// only when the block is idle; it then executes, looks up the peeked event in
// the ring memory (one registered read port) and loads the output register.
// A poll also scans the grid before the lookup, visiting one cell and
// pushing at most one event per cycle. The next command is taken in the
// cycle after the result is loaded. The result waits in the output register
// while the next command executes; if the receiver still stalls when that
// next result is ready, the block holds it and keeps in_stall high. Reset
// empties the queue, clears both maps and all statistics; ring data reaches
// the output only for a peek index below the entry count.
// ----------------------------------------------------------------------------
module sensor_matrix_change_event_queue_top #(
  parameter int QUEUE_DEPTH = smceq_pkg::QUEUE_DEPTH_DEF,
  parameter int GRID_ROWS   = smceq_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS   = smceq_pkg::GRID_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [smceq_pkg::KIND_W-1:0]      kind,
  input  logic [smceq_pkg::MAP_W-1:0]       sensor_bits,
  input  logic [smceq_pkg::TIME_W-1:0]      now_ms,
  input  logic [smceq_pkg::IDX_W-1:0]       peek_index,
  input  logic [smceq_pkg::IDX_W-1:0]       consume_count,
  input  logic [smceq_pkg::QRY_W-1:0]       query_row,
  input  logic [smceq_pkg::QRY_W-1:0]       query_col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [smceq_pkg::EKIND_W-1:0]     event_kind,
  output logic [smceq_pkg::POS_W-1:0]       event_row,
  output logic [smceq_pkg::POS_W-1:0]       event_col,
  output logic [smceq_pkg::TIME_W-1:0]      event_time,
  output logic [smceq_pkg::CNT_OUT_W-1:0]   queued_count,
  output logic                              overflow_flag,
  output logic [smceq_pkg::DROP_W-1:0]      dropped_count,
  output logic [smceq_pkg::CNT_OUT_W-1:0]   max_depth,
  output logic                              occupied,
  output logic                              was_lifted,
  output logic                              was_placed
);
  import smceq_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  smceq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  smceq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .GRID_ROWS   (GRID_ROWS),
    .GRID_COLS   (GRID_COLS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .kind          (kind),
    .sensor_bits   (sensor_bits),
    .now_ms        (now_ms),
    .peek_index    (peek_index),
    .consume_count (consume_count),
    .query_row     (query_row),
    .query_col     (query_col),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .event_row     (event_row),
    .event_col     (event_col),
    .event_time    (event_time),
    .queued_count  (queued_count),
    .overflow_flag (overflow_flag),
    .dropped_count (dropped_count),
    .max_depth     (max_depth),
    .occupied      (occupied),
    .was_lifted    (was_lifted),
    .was_placed    (was_placed)
  );

endmodule

### design/smceq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor matrix change event queue: controller
// Sequences accept, command execution, cell scan, ring lookup and output load.
// ----------------------------------------------------------------------------
module smceq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  smceq_pkg::ctl_status_t status,
  output smceq_pkg::ctl_cmd_t    cmd
);
  import smceq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = status.is_poll ? ST_SCAN : ST_LOOKUP;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall     = rst;
        cmd.latch_in = in_valid && !rst;
      end
      ST_EXEC: begin
        cmd.apply = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      ST_FETCH: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

### design/smceq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor matrix change event queue: datapath
// Occupancy maps, event ring memory, queue pointers, statistics, output stage.
// ----------------------------------------------------------------------------
module smceq_datapath #(
  parameter int QUEUE_DEPTH = smceq_pkg::QUEUE_DEPTH_DEF,
  parameter int GRID_ROWS   = smceq_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS   = smceq_pkg::GRID_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  smceq_pkg::ctl_cmd_t               cmd,
  output smceq_pkg::ctl_status_t            status,
  input  logic [smceq_pkg::KIND_W-1:0]      kind,
  input  logic [smceq_pkg::MAP_W-1:0]       sensor_bits,
  input  logic [smceq_pkg::TIME_W-1:0]      now_ms,
  input  logic [smceq_pkg::IDX_W-1:0]       peek_index,
  input  logic [smceq_pkg::IDX_W-1:0]       consume_count,
  input  logic [smceq_pkg::QRY_W-1:0]       query_row,
  input  logic [smceq_pkg::QRY_W-1:0]       query_col,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [smceq_pkg::EKIND_W-1:0]     event_kind,
  output logic [smceq_pkg::POS_W-1:0]       event_row,
  output logic [smceq_pkg::POS_W-1:0]       event_col,
  output logic [smceq_pkg::TIME_W-1:0]      event_time,
  output logic [smceq_pkg::CNT_OUT_W-1:0]   queued_count,
  output logic                              overflow_flag,
  output logic [smceq_pkg::DROP_W-1:0]      dropped_count,
  output logic [smceq_pkg::CNT_OUT_W-1:0]   max_depth,
  output logic                              occupied,
  output logic                              was_lifted,
  output logic                              was_placed
);
  import smceq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = $clog2(2 * QUEUE_DEPTH);
  localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [POS_W-1:0]  ROW_LAST = POS_W'(GRID_ROWS - 1);
  localparam logic [POS_W-1:0]  COL_LAST = POS_W'(GRID_COLS - 1);
  localparam logic [MAP_W-1:0]  GRID_MASK = grid_mask(GRID_ROWS, GRID_COLS);

  function automatic logic [PTR_W-1:0] wrap_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = a + b;
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return PTR_W'(s);
  endfunction

  // latched command
  logic [KIND_W-1:0] kind_q;
  logic [MAP_W-1:0]  snap_q;
  logic [TIME_W-1:0] now_q;
  logic [IDX_W-1:0]  peek_q;
  logic [IDX_W-1:0]  ncons_q;
  logic [QRY_W-1:0]  qrow_q;
  logic [QRY_W-1:0]  qcol_q;

  // architectural state
  logic [MAP_W-1:0]  current_map;
  logic [MAP_W-1:0]  previous_map;
  logic [PTR_W-1:0]  head_pointer;
  logic [CNT_W-1:0]  entry_count;
  logic              overflow_bit;
  logic [DROP_W-1:0] drop_counter;
  logic [CNT_W-1:0]  high_water;

  // scan position
  logic [POS_W-1:0]  scan_row;
  logic [POS_W-1:0]  scan_col;

  // ring memory
  event_t            ring [QUEUE_DEPTH];
  event_t            rd_data;
  logic              peek_ok;

  logic [BIT_W-1:0]  scan_idx;
  logic              cell_changed;
  logic              queue_full;
  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  take;
  logic [PTR_W-1:0]  head_cons;
  logic [PTR_W-1:0]  push_slot;
  logic [PTR_W-1:0]  rd_addr;
  logic              mem_we;
  logic [PTR_W-1:0]  wr_addr;
  event_t            wr_data;
  logic              sync_apply;
  logic              qry_ok;
  logic [BIT_W-1:0]  qry_idx;

  assign scan_idx     = {scan_row, scan_col};
  assign cell_changed = current_map[scan_idx] ^ snap_q[scan_idx];
  assign queue_full   = (entry_count == DEPTH_C);
  assign count_inc    = entry_count + CNT_W'(1);
  assign take         = (IDX_W'(entry_count) < ncons_q) ? entry_count : CNT_W'(ncons_q);
  assign head_cons    = wrap_add(SUM_W'(head_pointer), SUM_W'(take));
  assign push_slot    = wrap_add(SUM_W'(head_pointer), SUM_W'(entry_count));
  assign rd_addr      = wrap_add(SUM_W'(head_pointer), SUM_W'(peek_q));
  assign sync_apply   = cmd.apply && (kind_q == CMD_SYNC);

  assign status.is_poll   = (kind_q == CMD_POLL);
  assign status.scan_done = (scan_row == ROW_LAST) && (scan_col == COL_LAST);
  assign status.out_free  = !out_valid || !out_stall;

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = push_slot;
    wr_data = '{kind: snap_q[scan_idx] ? EVT_PLACED : EVT_LIFTED,
                row: scan_row, col: scan_col, stamp: now_q};
    if (sync_apply) begin
      mem_we  = 1'b1;
      wr_addr = '0;
      wr_data = '{kind: EVT_SYNCED, row: '0, col: '0, stamp: now_q};
    end else if (cmd.scan_step && cell_changed && !queue_full) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_addr] <= wr_data;
    end
    if (cmd.lookup) begin
      rd_data <= ring[rd_addr];
      peek_ok <= (IDX_W'(entry_count) > peek_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_q  <= kind;
      snap_q  <= sensor_bits;
      now_q   <= now_ms;
      peek_q  <= peek_index;
      ncons_q <= consume_count;
      qrow_q  <= query_row;
      qcol_q  <= query_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_map  <= '0;
      previous_map <= '0;
      head_pointer <= '0;
      entry_count  <= '0;
      overflow_bit <= 1'b0;
      drop_counter <= '0;
      high_water   <= '0;
      scan_row     <= '0;
      scan_col     <= '0;
    end else begin
      if (cmd.apply) begin
        case (kind_q)
          CMD_POLL: begin
            previous_map <= current_map;
            scan_row     <= '0;
            scan_col     <= '0;
          end
          CMD_SYNC: begin
            current_map  <= snap_q & GRID_MASK;
            previous_map <= snap_q & GRID_MASK;
            head_pointer <= '0;
            entry_count  <= CNT_W'(1);
            overflow_bit <= 1'b0;
            drop_counter <= '0;
            high_water   <= CNT_W'(1);
          end
          CMD_CONSUME: begin
            head_pointer <= head_cons;
            entry_count  <= entry_count - take;
          end
          CMD_CLEAR_QUEUE: begin
            head_pointer <= '0;
            entry_count  <= '0;
          end
          CMD_CLEAR_OVF: begin
            overflow_bit <= 1'b0;
            drop_counter <= '0;
            high_water   <= entry_count;
          end
          default: begin
          end
        endcase
      end
      if (cmd.scan_step) begin
        if (scan_col == COL_LAST) begin
          scan_col <= '0;
          scan_row <= scan_row + POS_W'(1);
        end else begin
          scan_col <= scan_col + POS_W'(1);
        end
        if (cell_changed) begin
          current_map[scan_idx] <= snap_q[scan_idx];
          if (queue_full) begin
            overflow_bit <= 1'b1;
            if (drop_counter != '1) begin
              drop_counter <= drop_counter + DROP_W'(1);
            end
          end else begin
            entry_count <= count_inc;
            if (count_inc > high_water) begin
              high_water <= count_inc;
            end
          end
        end
      end
    end
  end

  assign qry_ok  = (qrow_q < QRY_W'(GRID_ROWS)) && (qcol_q < QRY_W'(GRID_COLS));
  assign qry_idx = {qrow_q[POS_W-1:0], qcol_q[POS_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      event_kind    <= peek_ok ? rd_data.kind  : EVT_SYNCED;
      event_row     <= peek_ok ? rd_data.row   : '0;
      event_col     <= peek_ok ? rd_data.col   : '0;
      event_time    <= peek_ok ? rd_data.stamp : '0;
      queued_count  <= CNT_OUT_W'(entry_count);
      overflow_flag <= overflow_bit;
      dropped_count <= drop_counter;
      max_depth     <= CNT_OUT_W'(high_water);
      occupied      <= qry_ok && current_map[qry_idx];
      was_lifted    <= qry_ok && previous_map[qry_idx] && !current_map[qry_idx];
      was_placed    <= qry_ok && !previous_map[qry_idx] && current_map[qry_idx];
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor matrix change event queue: testbench
// Drives command transactions into the block under random sender and receiver
// idling, and predicts each result from a behavioral copy of the sensor maps,
// event ring and drop statistics, or from the table for typed rows. A short
// directed table covers reset state, grid and timestamp extremes, a flooded
// queue, out-of-range peeks and cell queries, and the unused command codes.
// Random commands follow, with a long output hold-off that backs the block up,
// and a run of full-grid toggling polls that saturates the drop counter.
// ----------------------------------------------------------------------------
module tb_top;
  import smceq_pkg::*;

  localparam logic [KIND_W-1:0] CMD_RSVD_LO = 3'd6;
  localparam logic [KIND_W-1:0] CMD_RSVD_HI = 3'd7;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int DRAIN_CYCLES     = 100;
  localparam int HOLD_CYCLES      = 400;
  localparam int FIRST_RANDOM     = 300;
  localparam int SATURATION_POLLS = 1040;
  localparam int LAST_RANDOM      = 600;
  localparam int DIRECTED_ROWS    = 20;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [MAP_W-1:0]  sensor;
    logic [TIME_W-1:0] stamp;
    logic [IDX_W-1:0]  peek;
    logic [IDX_W-1:0]  consume;
    logic [QRY_W-1:0]  qrow;
    logic [QRY_W-1:0]  qcol;
  } command_t;

  typedef struct {
    logic [EKIND_W-1:0]   ev_kind;
    logic [POS_W-1:0]     ev_row;
    logic [POS_W-1:0]     ev_col;
    logic [TIME_W-1:0]    ev_time;
    logic [CNT_OUT_W-1:0] depth_now;
    logic                 ovf;
    logic [DROP_W-1:0]    drops;
    logic [CNT_OUT_W-1:0] depth_peak;
    logic                 occ;
    logic                 lifted;
    logic                 placed;
  } report_t;

  typedef struct {
    command_t cmd;
    bit       typed;
    report_t  want;
  } directed_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  command_t drive_cmd = '{default: '0};
  bit drive_typed = 1'b0;
  report_t drive_want = '{default: '0};

  logic                 in_stall;
  logic                 out_valid;
  logic [EKIND_W-1:0]   event_kind;
  logic [POS_W-1:0]     event_row;
  logic [POS_W-1:0]     event_col;
  logic [TIME_W-1:0]    event_time;
  logic [CNT_OUT_W-1:0] queued_count;
  logic                 overflow_flag;
  logic [DROP_W-1:0]    dropped_count;
  logic [CNT_OUT_W-1:0] max_depth;
  logic                 occupied;
  logic                 was_lifted;
  logic                 was_placed;

  int send_idle_pct = 26;
  int recv_idle_pct = 62;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int error_count = 0;
  int cycle_count = 0;

  report_t pending_reports[$];

  logic [MAP_W-1:0] occupancy_now = '0;
  logic [MAP_W-1:0] occupancy_before = '0;
  event_t           event_log [QUEUE_DEPTH_DEF];
  int unsigned      log_head = 0;
  int unsigned      log_fill = 0;
  logic             overflow_seen = 1'b0;
  int unsigned      drops_total = 0;
  int unsigned      fill_peak = 0;

  directed_row_t directed_table [DIRECTED_ROWS] = '{
    '{'{CMD_PEEK, 64'h0, 32'h0, 8'd0, 8'd0, 4'd0, 4'd0}, 1'b1,
      '{2'd0, 3'd0, 3'd0, 32'h0, 6'd0, 1'b0, 16'd0, 6'd0, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_RSVD_LO, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 4'hF, 4'hF},
      1'b1, '{2'd0, 3'd0, 3'd0, 32'h0, 6'd0, 1'b0, 16'd0, 6'd0, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_RSVD_HI, 64'h0, 32'h0, 8'd0, 8'd0, 4'd7, 4'd7}, 1'b1,
      '{2'd0, 3'd0, 3'd0, 32'h0, 6'd0, 1'b0, 16'd0, 6'd0, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_SYNC, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 8'hFF, 4'd7, 4'd7},
      1'b1, '{EVT_SYNCED, 3'd0, 3'd0, 32'hFFFF_FFFF, 6'd1, 1'b0, 16'd0, 6'd1,
      1'b1, 1'b0, 1'b0}},
    '{'{CMD_POLL, 64'h0, 32'h0, 8'd0, 8'd0, 4'd0, 4'd0}, 1'b1,
      '{EVT_SYNCED, 3'd0, 3'd0, 32'hFFFF_FFFF, 6'd32, 1'b1, 16'd33, 6'd32,
      1'b0, 1'b1, 1'b0}},
    '{'{CMD_PEEK, 64'h0, 32'h0, 8'd31, 8'd0, 4'd8, 4'd0}, 1'b0, '{default: '0}},
    '{'{CMD_PEEK, 64'h0, 32'h0, 8'd32, 8'd0, 4'd0, 4'd8}, 1'b1,
      '{2'd0, 3'd0, 3'd0, 32'h0, 6'd32, 1'b1, 16'd33, 6'd32, 1'b0, 1'b0, 1'b0}},
    '{'{CMD_POLL, 64'h0, 32'd5, 8'd0, 8'd0, 4'd0, 4'd0}, 1'b0, '{default: '0}},
    '{'{CMD_POLL, 64'hFFFF_FFFF_FFFF_FFFF, 32'h89AB_CDEF, 8'd1, 8'd0, 4'd3, 4'd4},
      1'b0, '{default: '0}},
    '{'{CMD_CLEAR_OVF, 64'h0, 32'h0, 8'd0, 8'd0, 4'd7, 4'd0}, 1'b0, '{default: '0}},
    '{'{CMD_CONSUME, 64'h0, 32'h0, 8'd0, 8'hFF, 4'd7, 4'd0}, 1'b0, '{default: '0}},
    '{'{CMD_CONSUME, 64'h0, 32'h0, 8'd0, 8'd0, 4'd2, 4'd2}, 1'b0, '{default: '0}},
    '{'{CMD_POLL, 64'hAA55_AA55_AA55_AA55, 32'h1234_5678, 8'd0, 8'd0, 4'd0, 4'd1},
      1'b0, '{default: '0}},
    '{'{CMD_PEEK, 64'h0, 32'h0, 8'hFF, 8'd0, 4'd0, 4'd0}, 1'b0, '{default: '0}},
    '{'{CMD_CONSUME, 64'h0, 32'h0, 8'd0, 8'd3, 4'd1, 4'd0}, 1'b0, '{default: '0}},
    '{'{CMD_POLL, 64'h0000_0000_0000_0001, 32'h0000_0001, 8'd2, 8'd0, 4'd0, 4'd0},
      1'b0, '{default: '0}},
    '{'{CMD_CLEAR_QUEUE, 64'h0, 32'h0, 8'd0, 8'd0, 4'd0, 4'd0}, 1'b0, '{default: '0}},
    '{'{CMD_POLL, 64'h8000_0000_0000_0000, 32'h8000_0000, 8'd0, 8'd0, 4'd7, 4'd7},
      1'b0, '{default: '0}},
    '{'{CMD_PEEK, 64'h0, 32'h0, 8'd0, 8'd0, 4'hF, 4'hF}, 1'b0, '{default: '0}},
    '{'{CMD_CLEAR_OVF, 64'h0, 32'h0, 8'd0, 8'd0, 4'd0, 4'd7}, 1'b0, '{default: '0}}
  };

  sensor_matrix_change_event_queue_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (drive_cmd.kind),
    .sensor_bits  (drive_cmd.sensor),
    .now_ms       (drive_cmd.stamp),
    .peek_index   (drive_cmd.peek),
    .consume_count(drive_cmd.consume),
    .query_row    (drive_cmd.qrow),
    .query_col    (drive_cmd.qcol),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .event_row    (event_row),
    .event_col    (event_col),
    .event_time   (event_time),
    .queued_count (queued_count),
    .overflow_flag(overflow_flag),
    .dropped_count(dropped_count),
    .max_depth    (max_depth),
    .occupied     (occupied),
    .was_lifted   (was_lifted),
    .was_placed   (was_placed)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void log_event(logic [EKIND_W-1:0] k, int r, int c,
                                    logic [TIME_W-1:0] t);
    if (log_fill >= QUEUE_DEPTH_DEF) begin
      overflow_seen = 1'b1;
      if (drops_total < 32'hFFFF) begin
        drops_total++;
      end
    end else begin
      event_log[(log_head + log_fill) % QUEUE_DEPTH_DEF] = '{k, 3'(r), 3'(c), t};
      log_fill++;
      if (log_fill > fill_peak) begin
        fill_peak = log_fill;
      end
    end
  endfunction

  function automatic void clear_drop_stats();
    overflow_seen = 1'b0;
    drops_total = 0;
    fill_peak = log_fill;
  endfunction

  function automatic report_t apply_command(command_t c);
    report_t     res;
    event_t      e;
    int unsigned n;
    int          pos;
    res = '{default: '0};
    case (c.kind)
      CMD_POLL: begin
        occupancy_before = occupancy_now;
        for (pos = 0; pos < MAP_W; pos++) begin
          if (occupancy_now[pos] != c.sensor[pos]) begin
            occupancy_now[pos] = c.sensor[pos];
            log_event(c.sensor[pos] ? EVT_PLACED : EVT_LIFTED, pos / 8, pos % 8,
                      c.stamp);
          end
        end
      end
      CMD_SYNC: begin
        occupancy_now = c.sensor;
        occupancy_before = c.sensor;
        log_head = 0;
        log_fill = 0;
        clear_drop_stats();
        log_event(EVT_SYNCED, 0, 0, c.stamp);
      end
      CMD_CONSUME: begin
        n = (c.consume > log_fill) ? log_fill : c.consume;
        log_head = (log_head + n) % QUEUE_DEPTH_DEF;
        log_fill -= n;
      end
      CMD_CLEAR_QUEUE: begin
        log_head = 0;
        log_fill = 0;
      end
      CMD_CLEAR_OVF: begin
        clear_drop_stats();
      end
      default: begin
      end
    endcase
    if (c.peek < log_fill) begin
      e = event_log[(log_head + c.peek) % QUEUE_DEPTH_DEF];
      res.ev_kind = e.kind;
      res.ev_row = e.row;
      res.ev_col = e.col;
      res.ev_time = e.stamp;
    end
    res.depth_now = CNT_OUT_W'(log_fill);
    res.ovf = overflow_seen;
    res.drops = DROP_W'(drops_total);
    res.depth_peak = CNT_OUT_W'(fill_peak);
    if (c.qrow < 8 && c.qcol < 8) begin
      pos = c.qrow * 8 + c.qcol;
      res.occ = occupancy_now[pos];
      res.lifted = occupancy_before[pos] && !occupancy_now[pos];
      res.placed = !occupancy_before[pos] && occupancy_now[pos];
    end
    return res;
  endfunction

  function automatic command_t random_command();
    command_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 36) c.kind = CMD_POLL;
    else if (pick < 44) c.kind = CMD_SYNC;
    else if (pick < 62) c.kind = CMD_PEEK;
    else if (pick < 78) c.kind = CMD_CONSUME;
    else if (pick < 84) c.kind = CMD_CLEAR_QUEUE;
    else if (pick < 92) c.kind = CMD_CLEAR_OVF;
    else if (pick < 96) c.kind = CMD_RSVD_LO;
    else c.kind = CMD_RSVD_HI;
    case ($urandom_range(0, 9))
      0: c.sensor = {$urandom, $urandom};
      1: c.sensor = $urandom_range(0, 1) ? '1 : '0;
      default: begin
        c.sensor = occupancy_now;
        repeat ($urandom_range(0, 4)) c.sensor[$urandom_range(0, MAP_W - 1)] ^= 1'b1;
      end
    endcase
    c.stamp = $urandom;
    c.peek = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 255))
                                         : IDX_W'($urandom_range(0, 33));
    c.consume = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 255))
                                            : IDX_W'($urandom_range(0, 6));
    c.qrow = ($urandom_range(0, 3) == 0) ? QRY_W'($urandom_range(0, 15))
                                         : QRY_W'($urandom_range(0, 7));
    c.qcol = ($urandom_range(0, 3) == 0) ? QRY_W'($urandom_range(0, 15))
                                         : QRY_W'($urandom_range(0, 7));
    return c;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_command(input command_t c, input bit typed, input report_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    drive_cmd <= c;
    drive_typed <= typed;
    drive_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    report_t model;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{event_kind, event_row, event_col, event_time, queued_count, overflow_flag,
                dropped_count, max_depth, occupied, was_lifted, was_placed};
        if (pending_reports.size() == 0) begin
          $display("%0t ns: result with nothing pending", $time);
          error_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("event_kind", 64'(want.ev_kind), 64'(got.ev_kind));
          check_field("event_row", 64'(want.ev_row), 64'(got.ev_row));
          check_field("event_col", 64'(want.ev_col), 64'(got.ev_col));
          check_field("event_time", 64'(want.ev_time), 64'(got.ev_time));
          check_field("queued_count", 64'(want.depth_now), 64'(got.depth_now));
          check_field("overflow_flag", 64'(want.ovf), 64'(got.ovf));
          check_field("dropped_count", 64'(want.drops), 64'(got.drops));
          check_field("max_depth", 64'(want.depth_peak), 64'(got.depth_peak));
          check_field("occupied", 64'(want.occ), 64'(got.occ));
          check_field("was_lifted", 64'(want.lifted), 64'(got.lifted));
          check_field("was_placed", 64'(want.placed), 64'(got.placed));
        end
      end
      if (in_valid && !in_stall) begin
        model = apply_command(drive_cmd);
        pending_reports.push_back(drive_typed ? drive_want : model);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    command_t c;
    report_t  blank;
    blank = '{default: '0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_table[i]) begin
      send_command(directed_table[i].cmd, directed_table[i].typed, directed_table[i].want);
    end

    // hold the output while commands keep arriving
    hold_requests <= hold_requests + 1;
    repeat (FIRST_RANDOM) send_command(random_command(), 1'b0, blank);

    send_idle_pct = 62;
    recv_idle_pct = 26;
    for (int i = 0; i < SATURATION_POLLS; i++) begin
      c = random_command();
      c.kind = CMD_POLL;
      c.sensor = i[0] ? '1 : '0;
      send_command(c, 1'b0, blank);
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (LAST_RANDOM) send_command(random_command(), 1'b0, blank);
    in_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
